FILE: design/polyphase_matched_filter_peak_search_macros.svh
// Assertion macros for the polyphase matched filter peak search block.
// Depends on clk and arst_n being visible in the module that expands them.
`ifndef POLYPHASE_MATCHED_FILTER_PEAK_SEARCH_MACROS_SVH
`define POLYPHASE_MATCHED_FILTER_PEAK_SEARCH_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PMFPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pmfps assertion failed");

// Antecedent implies consequent in the next cycle.
`define PMFPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pmfps assertion failed");

`endif

FILE: design/pmfps_pkg.sv
// Package for the polyphase matched filter peak search block.
// Holds field widths and the sequencer state type; depends on nothing.
package pmfps_pkg;

	localparam int SMP_W   = 16;
	localparam int TAPV_W  = 16;
	localparam int TAPI_W  = 7;
	localparam int SHIFT_W = 5;
	localparam int PHASE_W = 3;
	localparam int FINE_W  = 4;
	localparam int ACC_W   = 40;
	localparam int HALF_W  = ACC_W / 2;
	localparam int POW_W   = 2 * ACC_W;
	localparam int WIN_W   = 4;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [ADDR_W-1:0] ADDR_WINDOW = 3'd0;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TAP    = 1'b1;

	// Power pass steps: three partial squares of re, then of im
	localparam logic [2:0] PSTEP_LAST_MUL = 3'd5;
	localparam logic [2:0] PSTEP_LAST_ADD = 3'd6;
	localparam logic [2:0] PSTEP_CMP      = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MAC  = 4'b0010,
		S_PWR  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

endpackage

FILE: design/polyphase_matched_filter_peak_search.sv
// Throughput: one MAC per cycle through the sample and tap memory ports, one 20x20
// multiplier for the power; input stalls while a mark is searched, and tap writes
// never start a search. Reset: arst_n clears control, window (to 4),
// marks and fill count; the sample line reads as zero until filled, taps undefined.
module polyphase_matched_filter_peak_search #(
	parameter int BRANCHES    = 8,
	parameter int BRANCH_TAPS = 16,
	parameter int MAX_WINDOW  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// APB configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [pmfps_pkg::ADDR_W-1:0]         paddr,
	input  logic [pmfps_pkg::DATA_W-1:0]         pwdata,
	output logic [pmfps_pkg::DATA_W-1:0]         prdata,
	output logic                                 pready,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic signed [pmfps_pkg::SMP_W-1:0]   sample_re,
	input  logic signed [pmfps_pkg::SMP_W-1:0]   sample_im,
	input  logic                                 pulse_mark,
	input  logic [pmfps_pkg::TAPI_W-1:0]         tap_index,
	input  logic signed [pmfps_pkg::TAPV_W-1:0]  tap_value,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pmfps_pkg::SHIFT_W-1:0] best_shift,
	output logic [pmfps_pkg::PHASE_W-1:0]        best_phase,
	output logic signed [pmfps_pkg::FINE_W-1:0]  fine_time_steps,
	output logic signed [pmfps_pkg::ACC_W-1:0]   match_re,
	output logic signed [pmfps_pkg::ACC_W-1:0]   match_im
);
	import pmfps_pkg::*;

	localparam int DEPTH = 2 * MAX_WINDOW + BRANCH_TAPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int TC    = BRANCHES * BRANCH_TAPS;
	localparam int TAW   = $clog2(TC);
	localparam int KW    = $clog2(BRANCH_TAPS + 1);
	localparam int BW    = $clog2(BRANCHES);
	localparam int WUW   = $clog2(MAX_WINDOW + 2);
	localparam int WW    = WUW + 1;
	localparam int MIDX  = BRANCH_TAPS - BRANCH_TAPS / 2 - 1;

	// memories
	logic [2*SMP_W-1:0]       smem [DEPTH];
	logic signed [TAPV_W-1:0] tmem [TC];

	// control and sequencer state
	state_t                   state_q;
	logic [WIN_W-1:0]         window_size_q;
	logic [AW-1:0]            wp_q;
	logic [FW-1:0]            fill_q;
	logic [DEPTH-1:0]         mark_q;
	logic [WUW-1:0]           win_q;
	logic signed [WW-1:0]     shift_q;
	logic [BW-1:0]            b_q;
	logic [KW-1:0]            k_q;
	logic [AW-1:0]            age_base_q;
	logic [AW-1:0]            age_q;
	logic [TAW-1:0]           tap_addr_q;
	logic [2:0]               p_q;

	// datapath registers
	logic                     vld_s1;
	logic                     smp_ok_s1;
	logic [2*SMP_W-1:0]       smp_s1;
	logic signed [TAPV_W-1:0] tap_s1;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;
	logic [ACC_W-1:0]         mag_re_q;
	logic [ACC_W-1:0]         mag_im_q;
	logic [POW_W-1:0]         prod_s1;
	logic [POW_W-1:0]         pow_q;
	logic [POW_W-1:0]         best_pow_q;
	logic signed [WW-1:0]     best_shift_q;
	logic [BW-1:0]            best_b_q;
	logic signed [ACC_W-1:0]  best_re_q;
	logic signed [ACC_W-1:0]  best_im_q;

	// output register
	logic                     out_valid_q;
	logic signed [SHIFT_W-1:0] out_shift_q;
	logic [PHASE_W-1:0]       out_phase_q;
	logic signed [FINE_W-1:0] out_fine_q;
	logic signed [ACC_W-1:0]  out_re_q;
	logic signed [ACC_W-1:0]  out_im_q;

	// combinational
	logic                     cfg_wr;
	logic                     in_acc;
	logic                     smp_acc;
	logic                     tap_acc;
	logic [WUW-1:0]           win_sat;
	logic [AW-1:0]            mark_idx;
	logic                     mark_hit;
	logic [AW-1:0]            wp_next;
	logic [AW:0]              raddr_diff;
	logic [AW-1:0]            raddr;
	logic                     issue;
	logic signed [2*SMP_W-1:0] prod_re;
	logic signed [2*SMP_W-1:0] prod_im;
	logic [HALF_W-1:0]        mul_a;
	logic [HALF_W-1:0]        mul_b;
	logic [ACC_W-1:0]         mul_p;
	logic [POW_W-1:0]         mul_shifted;
	logic                     last_cand;
	logic                     out_free;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_WINDOW);
	assign prdata   = (paddr == ADDR_WINDOW) ? DATA_W'(window_size_q) : '0;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign smp_acc  = in_acc && (req_type == REQ_SAMPLE);
	assign tap_acc  = in_acc && (req_type == REQ_TAP) && (int'(tap_index) < TC);

	// saturate the window and find the mark that completes now
	assign win_sat  = (int'(window_size_q) > MAX_WINDOW) ? WUW'(MAX_WINDOW)
							     : WUW'(window_size_q);
	assign mark_idx = AW'(int'(win_sat) + MIDX);
	assign mark_hit = (mark_idx == '0) ? pulse_mark : mark_q[mark_idx - AW'(1)];
	assign wp_next  = (int'(wp_q) == DEPTH - 1) ? '0 : wp_q + AW'(1);

	// circular read address of the sample at age_q
	assign raddr_diff = {1'b0, wp_q} - {1'b0, age_q};
	assign raddr      = raddr_diff[AW] ? AW'(raddr_diff + (AW+1)'(DEPTH)) : AW'(raddr_diff);
	assign issue      = (state_q == S_MAC) && (int'(k_q) < BRANCH_TAPS);

	assign prod_re = $signed(smp_s1[SMP_W-1:0]) * tap_s1;
	assign prod_im = $signed(smp_s1[2*SMP_W-1:SMP_W]) * tap_s1;

	// pick partial-square operands for the power pass
	always_comb begin
		mul_a       = '0;
		mul_b       = '0;
		mul_shifted = '0;
		case (p_q)
			3'd0: begin
				mul_a = mag_re_q[HALF_W-1:0];
				mul_b = mag_re_q[HALF_W-1:0];
			end
			3'd1: begin
				mul_a = mag_re_q[ACC_W-1:HALF_W];
				mul_b = mag_re_q[HALF_W-1:0];
			end
			3'd2: begin
				mul_a = mag_re_q[ACC_W-1:HALF_W];
				mul_b = mag_re_q[ACC_W-1:HALF_W];
			end
			3'd3: begin
				mul_a = mag_im_q[HALF_W-1:0];
				mul_b = mag_im_q[HALF_W-1:0];
			end
			3'd4: begin
				mul_a = mag_im_q[ACC_W-1:HALF_W];
				mul_b = mag_im_q[HALF_W-1:0];
			end
			3'd5: begin
				mul_a = mag_im_q[ACC_W-1:HALF_W];
				mul_b = mag_im_q[ACC_W-1:HALF_W];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
		case (p_q)
			3'd1, 3'd4: mul_shifted = POW_W'(mul_p) << (HALF_W + 1);
			3'd2, 3'd5: mul_shifted = POW_W'(mul_p) << ACC_W;
			default:    mul_shifted = POW_W'(mul_p);
		endcase
	end

	assign last_cand = (int'(b_q) == BRANCHES - 1) && (shift_q == $signed(WW'(win_q)));
	assign out_free  = !out_valid_q || !out_stall;

	// memories: write on accept, read one entry each per MAC step
	always_ff @(posedge clk) begin
		if (smp_acc) begin
			smem[wp_next] <= {sample_im, sample_re};
		end
		if (tap_acc) begin
			tmem[TAW'(tap_index)] <= tap_value;
		end
		smp_s1 <= smem[raddr];
		tap_s1 <= tmem[tap_addr_q];
	end

	// configuration, sample line bookkeeping and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			window_size_q <= WIN_W'(4);
			wp_q          <= AW'(DEPTH - 1);
			fill_q        <= '0;
			mark_q        <= '0;
			vld_s1        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				window_size_q <= pwdata[WIN_W-1:0];
			end
			if (smp_acc) begin
				wp_q   <= wp_next;
				mark_q <= {mark_q[DEPTH-2:0], pulse_mark};
				if (int'(fill_q) < DEPTH) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			vld_s1 <= issue;
			// load a new word or drop the one taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (smp_acc && mark_hit) begin
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (int'(k_q) == BRANCH_TAPS && !vld_s1) begin
						state_q <= S_PWR;
					end
				end
				S_PWR: begin
					if (p_q == PSTEP_CMP && last_cand) begin
						state_q <= S_DONE;
					end else if (p_q == PSTEP_CMP) begin
						state_q <= S_MAC;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: candidate counters, MAC, power pass, best tracking
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && smp_acc && mark_hit) begin
			win_q        <= win_sat;
			shift_q      <= -$signed(WW'(win_sat));
			b_q          <= '0;
			k_q          <= '0;
			age_base_q   <= AW'(2 * int'(win_sat) + BRANCH_TAPS - 1);
			age_q        <= AW'(2 * int'(win_sat) + BRANCH_TAPS - 1);
			tap_addr_q   <= '0;
			acc_re_q     <= '0;
			acc_im_q     <= '0;
			best_pow_q   <= '0;
			best_shift_q <= '0;
			best_b_q     <= '0;
			best_re_q    <= '0;
			best_im_q    <= '0;
		end
		if (issue) begin
			k_q        <= k_q + KW'(1);
			age_q      <= age_q - AW'(1);
			tap_addr_q <= tap_addr_q + TAW'(BRANCHES);
			smp_ok_s1  <= (FW'(age_q) < fill_q);
		end
		if (vld_s1) begin
			acc_re_q <= acc_re_q + (smp_ok_s1 ? ACC_W'(prod_re) : '0);
			acc_im_q <= acc_im_q + (smp_ok_s1 ? ACC_W'(prod_im) : '0);
		end
		if (state_q == S_MAC && int'(k_q) == BRANCH_TAPS && !vld_s1) begin
			mag_re_q <= acc_re_q[ACC_W-1] ? ACC_W'(-acc_re_q) : ACC_W'(acc_re_q);
			mag_im_q <= acc_im_q[ACC_W-1] ? ACC_W'(-acc_im_q) : ACC_W'(acc_im_q);
			p_q      <= '0;
			pow_q    <= '0;
		end
		if (state_q == S_PWR) begin
			p_q <= p_q + 3'd1;
			if (p_q <= PSTEP_LAST_MUL) begin
				prod_s1 <= mul_shifted;
			end
			if (p_q != '0 && p_q <= PSTEP_LAST_ADD) begin
				pow_q <= pow_q + prod_s1;
			end
			if (p_q == PSTEP_CMP) begin
				// keep the first strictly greater power
				if (pow_q > best_pow_q) begin
					best_pow_q   <= pow_q;
					best_shift_q <= shift_q;
					best_b_q     <= b_q;
					best_re_q    <= acc_re_q;
					best_im_q    <= acc_im_q;
				end
				// advance to the next branch, then the next shift
				k_q      <= '0;
				acc_re_q <= '0;
				acc_im_q <= '0;
				if (int'(b_q) == BRANCHES - 1) begin
					b_q        <= '0;
					shift_q    <= shift_q + WW'(1);
					age_base_q <= age_base_q - AW'(1);
					age_q      <= age_base_q - AW'(1);
					tap_addr_q <= '0;
				end else begin
					b_q        <= b_q + BW'(1);
					age_q      <= age_base_q;
					tap_addr_q <= TAW'(b_q) + TAW'(1);
				end
			end
		end
		if (state_q == S_DONE && out_free) begin
			out_shift_q <= SHIFT_W'(best_shift_q);
			out_phase_q <= PHASE_W'(best_b_q);
			out_fine_q  <= FINE_W'(BRANCHES / 2 - int'(best_b_q));
			out_re_q    <= best_re_q;
			out_im_q    <= best_im_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign best_shift      = out_shift_q;
	assign best_phase      = out_phase_q;
	assign fine_time_steps = out_fine_q;
	assign match_re        = out_re_q;
	assign match_im        = out_im_q;

`include "polyphase_matched_filter_peak_search_macros.svh"

	`PMFPS_ASSERT_NXT(a_mark_starts, (smp_acc && mark_hit), (state_q == S_MAC))
	`PMFPS_ASSERT_IMP(a_fill_bound, 1'b1, (int'(fill_q) <= DEPTH))
	`PMFPS_ASSERT_IMP(a_no_mac_in_pwr, (state_q == S_PWR), (!vld_s1))
	`PMFPS_ASSERT_IMP(a_done_from_pwr, ((state_q == S_DONE) && $changed(state_q)), ($past(state_q) == S_PWR))

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the polyphase matched filter peak search block.
// Depends on pmfps_pkg and the block itself; holds a scoreboard class and the drivers.
`timescale 1ns / 1ps

module testbench;
	import pmfps_pkg::*;

	typedef struct {
		logic signed [SHIFT_W-1:0] shift;
		logic [PHASE_W-1:0]        phase;
		logic signed [FINE_W-1:0]  fine;
		logic signed [ACC_W-1:0]   mre;
		logic signed [ACC_W-1:0]   mim;
	} peak_t;

	localparam int NBR   = 8;
	localparam int NTAP  = 16;
	localparam int MAXW  = 8;
	localparam int DEPTH = 2 * MAXW + NTAP;
	localparam int DRAIN = (2 * MAXW + 1) * NBR * (NTAP + 10) + 64;

	// Own copy of the block's state; predicts one peak per handled mark
	class peak_scoreboard;
		logic signed [SMP_W-1:0]  line_re[DEPTH];
		logic signed [SMP_W-1:0]  line_im[DEPTH];
		bit                       line_mark[DEPTH];
		logic signed [TAPV_W-1:0] taps[NBR*NTAP];
		int                       win;
		peak_t                    peaks[$];
		int                       errors;

		function new();
			win = 4;
			errors = 0;
			for (int i = 0; i < DEPTH; i++) begin
				line_re[i] = '0;
				line_im[i] = '0;
				line_mark[i] = 0;
			end
			foreach (taps[i]) taps[i] = '0;
		endfunction

		function void note_input(logic rt, logic signed [SMP_W-1:0] sre,
				logic signed [SMP_W-1:0] sim, logic mk, logic [TAPI_W-1:0] ti,
				logic signed [TAPV_W-1:0] tv);
			int ws;
			longint re, im;
			logic signed [POW_W+1:0] r2, i2, pw, best;
			peak_t pk;
			if (rt == REQ_TAP) begin
				if (ti < NBR * NTAP) taps[ti] = tv;
				return;
			end
			for (int i = DEPTH - 1; i > 0; i--) begin
				line_re[i] = line_re[i-1];
				line_im[i] = line_im[i-1];
				line_mark[i] = line_mark[i-1];
			end
			line_re[0] = sre;
			line_im[0] = sim;
			line_mark[0] = mk;
			ws = (win > MAXW) ? MAXW : win;
			if (!line_mark[ws + NTAP - NTAP/2 - 1]) return;
			best = '0;
			pk.shift = '0;
			pk.phase = '0;
			pk.fine = FINE_W'(NBR / 2);
			pk.mre = '0;
			pk.mim = '0;
			// Sweep every shift and branch, keep the first strict maximum
			for (int w = -ws; w <= ws; w++) begin
				for (int b = 0; b < NBR; b++) begin
					re = 0;
					im = 0;
					for (int k = 0; k < NTAP; k++) begin
						re += longint'(line_re[ws + NTAP - 1 - w - k]) * longint'(taps[b + NBR*k]);
						im += longint'(line_im[ws + NTAP - 1 - w - k]) * longint'(taps[b + NBR*k]);
					end
					r2 = (POW_W+2)'(re);
					i2 = (POW_W+2)'(im);
					pw = r2 * r2 + i2 * i2;
					if (pw > best) begin
						best = pw;
						pk.shift = SHIFT_W'(w);
						pk.phase = PHASE_W'(b);
						pk.fine = FINE_W'(NBR / 2 - b);
						pk.mre = re[ACC_W-1:0];
						pk.mim = im[ACC_W-1:0];
					end
				end
			end
			peaks.push_back(pk);
		endfunction

		function void check_result(peak_t got);
			peak_t e;
			if (peaks.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			e = peaks.pop_front();
			if (got.shift !== e.shift) begin
				$error("best_shift exp %0d got %0d", e.shift, got.shift); errors++;
			end
			if (got.phase !== e.phase) begin
				$error("best_phase exp %0d got %0d", e.phase, got.phase); errors++;
			end
			if (got.fine !== e.fine) begin
				$error("fine_time_steps exp %0d got %0d", e.fine, got.fine); errors++;
			end
			if (got.mre !== e.mre) begin
				$error("match_re exp %0d got %0d", e.mre, got.mre); errors++;
			end
			if (got.mim !== e.mim) begin
				$error("match_im exp %0d got %0d", e.mim, got.mim); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall, req_type = 0, pulse_mark = 0;
	logic signed [SMP_W-1:0] sample_re = '0, sample_im = '0;
	logic [TAPI_W-1:0] tap_index = '0;
	logic signed [TAPV_W-1:0] tap_value = '0;
	logic out_valid, out_stall = 1;
	logic signed [SHIFT_W-1:0] best_shift;
	logic [PHASE_W-1:0] best_phase;
	logic signed [FINE_W-1:0] fine_time_steps;
	logic signed [ACC_W-1:0] match_re, match_im;

	peak_scoreboard sb = new();
	int tx_idle = 0, rx_idle = 0, hold_cycles = 0;

	polyphase_matched_filter_peak_search dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		#400_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Receiver: random stall, or a long counted hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(0, 99) < rx_idle);
	end

	always @(posedge clk) begin
		peak_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.shift = best_shift;
			got.phase = best_phase;
			got.fine = fine_time_steps;
			got.mre = match_re;
			got.mim = match_im;
			sb.check_result(got);
		end
	end

	// Offer one word; called and returns at a falling edge
	task automatic send_word(logic rt, logic signed [SMP_W-1:0] sre,
			logic signed [SMP_W-1:0] sim, logic mk, logic [TAPI_W-1:0] ti,
			logic signed [TAPV_W-1:0] tv);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		req_type <= rt;
		sample_re <= sre;
		sample_im <= sim;
		pulse_mark <= mk;
		tap_index <= ti;
		tap_value <= tv;
		in_valid <= 1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(rt, sre, sim, mk, ti, tv);
		@(negedge clk);
	endtask

	task automatic send_sample(logic signed [SMP_W-1:0] sre, logic signed [SMP_W-1:0] sim,
			logic mk);
		send_word(REQ_SAMPLE, sre, sim, mk, TAPI_W'($urandom), TAPV_W'($urandom));
	endtask

	task automatic send_tap(logic [TAPI_W-1:0] ti, logic signed [TAPV_W-1:0] tv);
		send_word(REQ_TAP, SMP_W'($urandom), SMP_W'($urandom), 1'($urandom), ti, tv);
	endtask

	// Hold the sender until the block has drained
	task automatic drain();
		in_valid <= 0;
		while (sb.peaks.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_window(logic [DATA_W-1:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_WINDOW;
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.win = int'(val[WIN_W-1:0]);
	endtask

	function automatic logic signed [SMP_W-1:0] rand_smp();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	initial begin
		int wins[6];
		wins = '{0, 15, 8, 2, 5, 4};
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		tx_idle = 38;
		rx_idle = 62;

		// Directed: zero-power mark right after reset, then load every tap
		send_sample('0, '0, 1);
		repeat (5) send_sample('0, '0, 0);
		for (int i = 0; i < NBR * NTAP; i++)
			send_tap(TAPI_W'(i), (i % 9 == 0) ? 16'sh8000 : (i % 9 == 1) ? 16'sh7FFF :
				TAPV_W'($urandom));
		send_sample(16'sh7FFF, 16'sh8000, 1);
		send_sample(16'sh8000, 16'sh7FFF, 0);
		send_sample(16'sh8000, 16'sh8000, 1);
		send_sample(16'sh7FFF, 16'sh7FFF, 1);
		repeat (12) send_sample(rand_smp(), rand_smp(), 0);
		drain();

		// Random segments over several window settings and idling modes
		for (int seg = 0; seg < 6; seg++) begin
			write_window(DATA_W'(wins[seg]));
			tx_idle = (seg < 2) ? 38 : (seg < 4) ? 62 : 0;
			rx_idle = (seg < 2) ? 62 : (seg < 4) ? 38 : 0;
			if (seg == 0) hold_cycles = 3000;
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_tap(TAPI_W'($urandom_range(0, NBR * NTAP - 1)), rand_smp());
				else
					send_sample(rand_smp(), rand_smp(),
						(seg == 0 && n < 20) ? 1'b1 : ($urandom_range(0, 99) < 8));
			end
			drain();
		end

		if (sb.errors == 0 && sb.peaks.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
